// ===== hdl/rie_pkg.sv =====
// Package for the RISC-V instruction encoder: mnemonic codes, format codes,
// opcode constants, the per-mnemonic encoding table and shared structs.
// No dependencies.
`default_nettype none

package rie_pkg;

    // Field widths of one instruction request.
    localparam int unsigned CmdW  = 5;
    localparam int unsigned RegW  = 5;
    localparam int unsigned WordW = 32;

    // Base opcodes.
    localparam logic [6:0] OpReg    = 7'b0110011;
    localparam logic [6:0] OpImm    = 7'b0010011;
    localparam logic [6:0] OpLoad   = 7'b0000011;
    localparam logic [6:0] OpStore  = 7'b0100011;
    localparam logic [6:0] OpBranch = 7'b1100011;
    localparam logic [6:0] OpLui    = 7'b0110111;
    localparam logic [6:0] OpAuipc  = 7'b0010111;
    localparam logic [6:0] OpJal    = 7'b1101111;
    localparam logic [6:0] OpJalr   = 7'b1100111;

    // funct7 values.
    localparam logic [6:0] F7Base = 7'b0000000;
    localparam logic [6:0] F7Alt  = 7'b0100000;
    localparam logic [6:0] F7Mul  = 7'b0000001;

    // Largest 12-bit signed immediate; the check itself works on sign bits.
    localparam int Imm12Max = 2047;

    // Mnemonic codes as carried on the command field.
    typedef enum logic [CmdW-1:0] {
        CMD_ADD   = 5'd0,  CMD_AND  = 5'd1,  CMD_OR   = 5'd2,  CMD_SLL  = 5'd3,
        CMD_SLT   = 5'd4,  CMD_SRA  = 5'd5,  CMD_SRL  = 5'd6,  CMD_SUB  = 5'd7,
        CMD_XOR   = 5'd8,  CMD_MUL  = 5'd9,  CMD_DIV  = 5'd10, CMD_REM  = 5'd11,
        CMD_ADDI  = 5'd12, CMD_ANDI = 5'd13, CMD_ORI  = 5'd14, CMD_LB   = 5'd15,
        CMD_LD    = 5'd16, CMD_LH   = 5'd17, CMD_LW   = 5'd18, CMD_JALR = 5'd19,
        CMD_SB    = 5'd20, CMD_SW   = 5'd21, CMD_SD   = 5'd22, CMD_SH   = 5'd23,
        CMD_BEQ   = 5'd24, CMD_BNE  = 5'd25, CMD_BLT  = 5'd26, CMD_BGE  = 5'd27,
        CMD_AUIPC = 5'd28, CMD_LUI  = 5'd29, CMD_JAL  = 5'd30
    } t_cmd;

    // Instruction formats; FMT_BAD marks an unknown mnemonic.
    typedef enum logic [2:0] {
        FMT_R, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J, FMT_BAD
    } t_fmt;

    typedef struct packed {
        t_fmt       fmt;
        logic [6:0] opcode;
        logic [2:0] funct3;
        logic [6:0] funct7;
    } t_enc_entry;

    // One instruction request as held in the input register.
    typedef struct packed {
        logic [WordW-1:0] target_addr;
        logic [WordW-1:0] pc;
        logic [WordW-1:0] immediate;
        logic [RegW-1:0]  src2_reg;
        logic [RegW-1:0]  src1_reg;
        logic [RegW-1:0]  dest_reg;
        logic [CmdW-1:0]  command;
    } t_instr;

    // Encoded result.
    typedef struct packed {
        logic             status;
        logic [WordW-1:0] machine_word;
    } t_enc_result;

    function automatic t_enc_entry f_mk(t_fmt fmt, logic [6:0] op, logic [2:0] f3,
                                        logic [6:0] f7);
        t_enc_entry e;
        e.fmt    = fmt;
        e.opcode = op;
        e.funct3 = f3;
        e.funct7 = f7;
        return e;
    endfunction

    // Encoding table, one entry per mnemonic.
    function automatic t_enc_entry f_lookup(logic [CmdW-1:0] code);
        t_enc_entry e;
        case (t_cmd'(code))
            CMD_ADD:   e = f_mk(FMT_R, OpReg, 3'd0, F7Base);
            CMD_AND:   e = f_mk(FMT_R, OpReg, 3'd7, F7Base);
            CMD_OR:    e = f_mk(FMT_R, OpReg, 3'd6, F7Base);
            CMD_SLL:   e = f_mk(FMT_R, OpReg, 3'd1, F7Base);
            CMD_SLT:   e = f_mk(FMT_R, OpReg, 3'd2, F7Base);
            CMD_SRA:   e = f_mk(FMT_R, OpReg, 3'd5, F7Alt);
            CMD_SRL:   e = f_mk(FMT_R, OpReg, 3'd5, F7Base);
            CMD_SUB:   e = f_mk(FMT_R, OpReg, 3'd0, F7Alt);
            CMD_XOR:   e = f_mk(FMT_R, OpReg, 3'd4, F7Base);
            CMD_MUL:   e = f_mk(FMT_R, OpReg, 3'd0, F7Mul);
            CMD_DIV:   e = f_mk(FMT_R, OpReg, 3'd4, F7Mul);
            CMD_REM:   e = f_mk(FMT_R, OpReg, 3'd6, F7Mul);
            CMD_ADDI:  e = f_mk(FMT_I, OpImm, 3'd0, F7Base);
            CMD_ANDI:  e = f_mk(FMT_I, OpImm, 3'd7, F7Base);
            CMD_ORI:   e = f_mk(FMT_I, OpImm, 3'd6, F7Base);
            CMD_LB:    e = f_mk(FMT_I, OpLoad, 3'd0, F7Base);
            CMD_LD:    e = f_mk(FMT_I, OpLoad, 3'd3, F7Base);
            CMD_LH:    e = f_mk(FMT_I, OpLoad, 3'd1, F7Base);
            CMD_LW:    e = f_mk(FMT_I, OpLoad, 3'd2, F7Base);
            CMD_JALR:  e = f_mk(FMT_I, OpJalr, 3'd0, F7Base);
            CMD_SB:    e = f_mk(FMT_S, OpStore, 3'd0, F7Base);
            CMD_SW:    e = f_mk(FMT_S, OpStore, 3'd2, F7Base);
            CMD_SD:    e = f_mk(FMT_S, OpStore, 3'd3, F7Base);
            CMD_SH:    e = f_mk(FMT_S, OpStore, 3'd1, F7Base);
            CMD_BEQ:   e = f_mk(FMT_B, OpBranch, 3'd0, F7Base);
            CMD_BNE:   e = f_mk(FMT_B, OpBranch, 3'd1, F7Base);
            CMD_BLT:   e = f_mk(FMT_B, OpBranch, 3'd4, F7Base);
            CMD_BGE:   e = f_mk(FMT_B, OpBranch, 3'd5, F7Base);
            CMD_AUIPC: e = f_mk(FMT_U, OpAuipc, 3'd0, F7Base);
            CMD_LUI:   e = f_mk(FMT_U, OpLui, 3'd0, F7Base);
            CMD_JAL:   e = f_mk(FMT_J, OpJal, 3'd0, F7Base);
            default:   e = f_mk(FMT_BAD, 7'd0, 3'd0, F7Base);
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rie_encode.sv =====
// Combinational instruction encoder: table lookup, immediate range checks
// and field packing for the R, I, S, B, U and J formats.
// Depends on rie_pkg.
`default_nettype none

module rie_encode
    import rie_pkg::*;
(
    input  var t_instr      i_instr,
    output var t_enc_result o_result
);

    // Word bits 31..11 of a 12-bit signed immediate must all equal the sign.
    localparam int unsigned Imm12Bits = $clog2(Imm12Max + 1) + 1;

    t_enc_entry  w_entry;
    logic [31:0] w_off;
    logic [31:0] w_imm;
    logic        w_imm12_ok;
    logic        w_imm20_ok;

    assign w_entry = f_lookup(i_instr.command);
    assign w_imm   = i_instr.immediate;
    assign w_off   = i_instr.target_addr - i_instr.pc;

    // Range checks: 12-bit signed for I and S, 0..2^20-1 for U.
    assign w_imm12_ok = (w_imm[31:Imm12Bits-1] == '0) || (w_imm[31:Imm12Bits-1] == '1);
    assign w_imm20_ok = (w_imm[31:20] == 12'd0);

    // Pack the word for the selected format; errors give a zero word.
    always_comb begin
        o_result.machine_word = '0;
        o_result.status       = 1'b0;
        case (w_entry.fmt)
            FMT_R: begin
                o_result.machine_word = {w_entry.funct7, i_instr.src2_reg, i_instr.src1_reg,
                                         w_entry.funct3, i_instr.dest_reg, w_entry.opcode};
            end
            FMT_I: begin
                if (w_imm12_ok) begin
                    o_result.machine_word = {w_imm[11:0], i_instr.src1_reg, w_entry.funct3,
                                             i_instr.dest_reg, w_entry.opcode};
                end else begin
                    o_result.status = 1'b1;
                end
            end
            FMT_S: begin
                if (w_imm12_ok) begin
                    o_result.machine_word = {w_imm[11:5], i_instr.src2_reg, i_instr.src1_reg,
                                             w_entry.funct3, w_imm[4:0], w_entry.opcode};
                end else begin
                    o_result.status = 1'b1;
                end
            end
            FMT_B: begin
                o_result.machine_word = {w_off[12], w_off[10:5], i_instr.src2_reg,
                                         i_instr.src1_reg, w_entry.funct3, w_off[4:1],
                                         w_off[11], w_entry.opcode};
            end
            FMT_U: begin
                if (w_imm20_ok) begin
                    o_result.machine_word = {w_imm[19:0], i_instr.dest_reg, w_entry.opcode};
                end else begin
                    o_result.status = 1'b1;
                end
            end
            FMT_J: begin
                o_result.machine_word = {w_off[20], w_off[10:1], w_off[11], w_off[19:12],
                                         i_instr.dest_reg, w_entry.opcode};
            end
            default: begin
                o_result.status = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/riscv_instruction_encoder.sv =====
// An accepted input word is held in the input register and its encoded result
// then in the result register, where it waits until it is taken.
// Throughput: one word per cycle; the two stages advance whenever the result
// register is empty or its word is taken.
// Reset (synchronous, active low) empties both stages; there is no other state.
// Top level of the RISC-V instruction encoder. Depends on rie_pkg, rie_encode.
`default_nettype none

module riscv_instruction_encoder
    import rie_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Input word.
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: command[4:0], dest_reg[9:5], src1_reg[14:10],
    // src2_reg[19:15], immediate[51:20], pc[83:52], target_addr[115:84], zero pad
    input  wire  [119:0] s_axis_tdata,
    // Result word.
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // tdata from bit 0: machine_word[31:0], status[32], zero pad
    output logic [39:0]  m_axis_tdata
);

    t_instr      r_instr;
    logic        r_in_valid;
    t_enc_result r_result;
    logic        r_out_valid;
    t_enc_result w_result;
    logic        w_out_ready;
    logic        w_in_ready;

    // Each stage can load when it is empty or its content moves on.
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_in_ready    = !r_in_valid || w_out_ready;
    assign s_axis_tready = w_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && s_axis_tvalid) begin
            r_instr <= t_instr'(s_axis_tdata[$bits(t_instr)-1:0]);
        end
    end

    rie_encode u_encode (
        .i_instr  (r_instr),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_in_valid) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(40 - $bits(t_enc_result)){1'b0}}, r_result};

    // A word in the input stage reaches the result stage when it has room.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_ready) |=> r_out_valid)
        else $error("encoded word not moved into result register");

    // A flagged error never carries a nonzero word.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.status) |-> (r_result.machine_word == '0))
        else $error("error result with nonzero machine word");

    // An empty input stage always takes a new word.
    a_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled while input register is empty");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
